@@ hw/rtl/lfd_pkg.sv @@
// ----------------------------------------------------------------------------
// lfd_pkg
// Shared constants and types of the length framed packet deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfd_pkg;

  localparam int MAX_FRAME_DEF  = 64;
  localparam int FRAME_OVERHEAD = 4;

  localparam int BYTE_W    = 8;
  localparam int SIZE_W    = 6;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h01;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'hFE;

  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } lfd_wr_t;

  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] addr;
  } lfd_rd_t;

endpackage

`default_nettype wire

@@ hw/rtl/lfd_channels.sv @@
// ----------------------------------------------------------------------------
// lfd_channels
// Valid/ready channels of the deframer: receive bytes, results, configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lfd_in_if import lfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfd_out_if import lfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] operation;
  logic [SIZE_W-1:0] payload_size;
  logic [BYTE_W-1:0] data_byte;
  logic              data_valid;
  logic              last;

  modport source (
    output valid, output operation, output payload_size, output data_byte,
    output data_valid, output last, input ready
  );
  modport sink (
    input valid, input operation, input payload_size, input data_byte,
    input data_valid, input last, output ready
  );
endinterface

interface lfd_cfg_if import lfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/length_framed_packet_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// length_framed_packet_deframer_unit
// Decodes start / operation / length / payload / end frames from a byte stream.
// ----------------------------------------------------------------------------
// Receive bytes are taken one per cycle while a frame is being collected;
// payload bytes go into a single-port-write buffer memory. When the closing
// byte matches end_byte the receive side stalls and the payload is read back,
// one result per memory read, which is followed by a load of the output register;
// the next read waits until the previous result is loaded and the output register
// is empty or being taken, so back-pressure on the result side prolongs the stall. An empty
// frame gives one result, with data_valid low and last high. A bad closing
// byte or an out-of-range length drops the frame with no stall. Configuration
// writes are taken in any cycle and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module length_framed_packet_deframer_unit import lfd_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic  clk,
  input  logic  rst,
  lfd_in_if.sink    rx,
  lfd_out_if.source res,
  lfd_cfg_if.sink   cfg
);

  localparam int DEPTH = MAX_FRAME - FRAME_OVERHEAD;
  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_FRAME);
  localparam logic [BYTE_W-1:0] MIN_LEN = BYTE_W'(FRAME_OVERHEAD);

  typedef enum logic [2:0] {IDLE, OPER, LEN, BODY, EMIT} phase_t;

  phase_t            phase;
  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] end_byte;
  logic [BYTE_W-1:0] op_hold;
  logic [BYTE_W-1:0] frame_length;
  logic [BYTE_W-1:0] bytes_seen;
  logic [BYTE_W-1:0] rd_idx;
  logic              rd_pending;
  logic              rd_last;
  logic              rd_dvalid;

  logic [BYTE_W-1:0] size;
  logic [BYTE_W-1:0] rd_idx_inc;
  logic              rx_fire;
  logic              body_end;
  logic              issue;
  logic              issue_last;
  logic [BYTE_W-1:0] rd_data;
  lfd_wr_t           wr;
  lfd_rd_t           rd;

  assign rx.ready   = (phase != EMIT);
  assign cfg.ready  = 1'b1;
  assign rx_fire    = rx.valid && rx.ready;
  assign size       = frame_length - MIN_LEN;
  assign rd_idx_inc = rd_idx + 8'd1;
  assign body_end   = ({1'b0, bytes_seen} + 9'd1) >= {1'b0, frame_length};
  assign issue      = (phase == EMIT) && !rd_pending && (!res.valid || res.ready);
  assign issue_last = (size == '0) || (rd_idx_inc == size);

  // payload written at arrival index, read back in order
  assign wr.en   = rx_fire && (phase == BODY) && !body_end;
  assign wr.addr = bytes_seen - 8'd3;
  assign wr.data = rx.rx_byte;
  assign rd.en   = issue && (size != '0);
  assign rd.addr = rd_idx;

  lfd_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= IDLE;
      start_byte   <= START_BYTE_RST;
      end_byte     <= END_BYTE_RST;
      op_hold      <= '0;
      frame_length <= '0;
      bytes_seen   <= '0;
      rd_idx       <= '0;
      rd_pending   <= 1'b0;
      rd_last      <= 1'b0;
      rd_dvalid    <= 1'b0;
      res.valid    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_START_BYTE: start_byte <= cfg.data;
          REG_END_BYTE:   end_byte   <= cfg.data;
          default: ;
        endcase
      end

      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      if (rd_pending) begin
        res.valid        <= 1'b1;
        res.operation    <= op_hold;
        res.payload_size <= size[SIZE_W-1:0];
        res.data_byte    <= rd_dvalid ? rd_data : '0;
        res.data_valid   <= rd_dvalid;
        res.last         <= rd_last;
      end

      rd_pending <= issue;
      if (issue) begin
        rd_last   <= issue_last;
        rd_dvalid <= (size != '0);
        rd_idx    <= rd_idx_inc;
        if (issue_last) begin
          phase      <= IDLE;
          bytes_seen <= '0;
        end
      end

      if (rx_fire) begin
        case (phase)
          IDLE: begin
            if (rx.rx_byte == start_byte) begin
              phase      <= OPER;
              bytes_seen <= 8'd1;
            end
          end
          OPER: begin
            op_hold    <= rx.rx_byte;
            bytes_seen <= 8'd2;
            phase      <= LEN;
          end
          LEN: begin
            if (rx.rx_byte < MIN_LEN || rx.rx_byte > MAX_LEN) begin
              phase        <= IDLE;
              frame_length <= '0;
              bytes_seen   <= '0;
            end else begin
              frame_length <= rx.rx_byte;
              bytes_seen   <= 8'd3;
              phase        <= BODY;
            end
          end
          BODY: begin
            if (body_end) begin
              bytes_seen <= '0;
              if (rx.rx_byte == end_byte) begin
                phase  <= EMIT;
                rd_idx <= '0;
              end else begin
                phase <= IDLE;
              end
            end else begin
              bytes_seen <= bytes_seen + 8'd1;
            end
          end
          EMIT: ;
          default: phase <= IDLE;
        endcase
      end
    end
  end

  // read data always lands in an empty output register
  assert property (@(posedge clk) disable iff (rst) rd_pending |-> !res.valid)
    else $error("read data returned while output register busy");

  assert property (@(posedge clk) disable iff (rst) rd_pending |=> res.valid)
    else $error("read data not loaded into output register");

  assert property (@(posedge clk) disable iff (rst)
    (phase == EMIT) |-> (!rx.ready && !wr.en))
    else $error("receive path active during readout");

  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.data_valid || res.last))
    else $error("empty-frame result without last");

endmodule

`default_nettype wire

@@ hw/rtl/lfd_store.sv @@
// ----------------------------------------------------------------------------
// lfd_store
// Payload buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfd_store import lfd_pkg::*; #(
  parameter int DEPTH = MAX_FRAME_DEF - FRAME_OVERHEAD
) (
  input  logic              clk,
  input  lfd_wr_t           wr,
  input  lfd_rd_t           rd,
  output logic [BYTE_W-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

@@ sim/length_framed_packet_deframer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// length_framed_packet_deframer_unit_tb
// Sends framed and malformed byte streams under several start/end settings,
// predicts every deframed word and checks each one the block returns, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_framed_packet_deframer_unit_tb;
  import lfd_pkg::*;

  localparam int LIMIT_CYCLES = 200_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int STORE_DEPTH  = MAX_FRAME_DEF - FRAME_OVERHEAD;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;

  typedef enum logic [2:0] {RX_IDLE, RX_OPER, RX_LEN, RX_BODY} rx_phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] operation;
    logic [SIZE_W-1:0] payload_size;
    logic [BYTE_W-1:0] data_byte;
    logic              data_valid;
    logic              last;
  } deframed_word_t;

  class frame_scoreboard;
    logic [BYTE_W-1:0] start_b;
    logic [BYTE_W-1:0] end_b;
    logic [BYTE_W-1:0] op_hold;
    rx_phase_e         phase;
    logic [6:0]        frame_len;
    logic [6:0]        bytes_seen;
    logic [BYTE_W-1:0] payload [STORE_DEPTH];
    deframed_word_t    expected_words [$];
    int                mismatches;

    function new();
      start_b    = START_BYTE_RST;
      end_b      = END_BYTE_RST;
      op_hold    = '0;
      mismatches = 0;
      go_idle();
    endfunction

    function void go_idle();
      phase      = RX_IDLE;
      frame_len  = '0;
      bytes_seen = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
      if (idx == REG_START_BYTE) start_b = val;
      else if (idx == REG_END_BYTE) end_b = val;
    endfunction

    function void note_rx_byte(logic [BYTE_W-1:0] b);
      deframed_word_t w;
      int size;
      case (phase)
        RX_IDLE: begin
          if (b == start_b) begin
            phase      = RX_OPER;
            bytes_seen = 7'd1;
          end
        end
        RX_OPER: begin
          op_hold    = b;
          bytes_seen = 7'd2;
          phase      = RX_LEN;
        end
        RX_LEN: begin
          if (b < FRAME_OVERHEAD || b > MAX_FRAME_DEF) begin
            go_idle();
          end else begin
            frame_len  = b[6:0];
            bytes_seen = 7'd3;
            phase      = RX_BODY;
          end
        end
        default: begin
          if (bytes_seen + 7'd1 >= frame_len) begin
            if (b == end_b) begin
              size           = int'(frame_len) - FRAME_OVERHEAD;
              w.operation    = op_hold;
              w.payload_size = SIZE_W'(size);
              if (size == 0) begin
                w.data_byte  = '0;
                w.data_valid = 1'b0;
                w.last       = 1'b1;
                expected_words.push_back(w);
              end else begin
                for (int i = 0; i < size; i++) begin
                  w.data_byte  = payload[i];
                  w.data_valid = 1'b1;
                  w.last       = (i == size - 1);
                  expected_words.push_back(w);
                end
              end
            end
            go_idle();
          end else begin
            payload[bytes_seen - 7'd3] = b;
            bytes_seen++;
          end
        end
      endcase
    endfunction

    function string show(deframed_word_t w);
      return $sformatf("op=%02h size=%0d data=%02h dv=%0b last=%0b",
                       w.operation, w.payload_size, w.data_byte, w.data_valid, w.last);
    endfunction

    function void note_mismatch(string msg);
      if (mismatches < 10) $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endfunction

    function void check_word(deframed_word_t got);
      deframed_word_t exp_w;
      if (expected_words.size() == 0) begin
        note_mismatch({"unexpected word ", show(got)});
      end else begin
        exp_w = expected_words.pop_front();
        if (got.operation !== exp_w.operation || got.payload_size !== exp_w.payload_size ||
            got.data_byte !== exp_w.data_byte || got.data_valid !== exp_w.data_valid ||
            got.last !== exp_w.last)
          note_mismatch({"expected ", show(exp_w), " got ", show(got)});
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  lfd_in_if  rx ();
  lfd_out_if res ();
  lfd_cfg_if cfg ();

  length_framed_packet_deframer_unit u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx.sink),
    .res (res.source),
    .cfg (cfg.sink)
  );

  frame_scoreboard sb = new();

  bit idling_on = 1'b1;
  bit hold_req  = 1'b0;
  bit rx_on     = 1'b0;
  int bytes_sent = 0;

  logic [BYTE_W-1:0] directed_seq [29] = '{
    8'h00, 8'hFF,
    8'h01, 8'h00, 8'h04, 8'hFE,
    8'h01, 8'hFF, 8'h05, 8'h00, 8'hFE,
    8'h01, 8'h10, 8'h01,
    8'h05,
    8'h01, 8'h20, 8'h41,
    8'h01, 8'h22, 8'h05, 8'hAA, 8'h01,
    8'h01, 8'h33, 8'h06, 8'h01, 8'hFF, 8'hFE
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    rx_on = 1'b1;
    do @(posedge clk); while (!rx.ready);
    sb.note_rx_byte(b);
    bytes_sent++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      rx.valid <= 1'b0;
      rx_on = 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] op, input int len, input bit good_end);
    logic [BYTE_W-1:0] b;
    send_byte(sb.start_b);
    send_byte(op);
    send_byte(BYTE_W'(len));
    for (int i = 0; i < len - FRAME_OVERHEAD; i++) begin
      case ($urandom_range(0, 9))
        0:       b = sb.start_b;
        1:       b = sb.end_b;
        default: b = BYTE_W'($urandom_range(0, 255));
      endcase
      send_byte(b);
    end
    send_byte(good_end ? sb.end_b : sb.end_b ^ BYTE_W'($urandom_range(1, 255)));
  endtask

  // drop whatever frame is open so the next phase starts from idle
  task automatic finish_frame();
    while (sb.phase != RX_IDLE) begin
      case (sb.phase)
        RX_LEN:  send_byte('0);
        RX_BODY: send_byte(sb.end_b ^ 8'h01);
        default: send_byte(BYTE_W'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic drain_results();
    if (rx_on) begin
      rx.valid <= 1'b0;
      rx_on = 1'b0;
    end
    do @(posedge clk); while (sb.expected_words.size() != 0);
  endtask

  task automatic quiesce();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, val);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int budget, input bit with_pause);
    int first;
    int len;
    bit paused;
    first  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - first < budget) begin
      case ($urandom_range(0, 9))
        0: send_byte(BYTE_W'($urandom_range(0, 255)));
        1: begin
          send_byte(sb.start_b);
          send_byte(BYTE_W'($urandom_range(0, 255)));
          send_byte($urandom_range(0, 1) ? BYTE_W'($urandom_range(0, 3))
                                         : BYTE_W'($urandom_range(65, 255)));
        end
        2: send_frame(BYTE_W'($urandom_range(0, 255)), $urandom_range(4, 10), 1'b0);
        default: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, MAX_FRAME_DEF)
                                            : $urandom_range(4, 10);
          send_frame(BYTE_W'($urandom_range(0, 255)), len, 1'b1);
        end
      endcase
      if (with_pause && !paused && bytes_sent - first > budget / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin : result_sink
    deframed_word_t got;
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    res.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) begin
        got.operation    = res.operation;
        got.payload_size = res.payload_size;
        got.data_byte    = res.data_byte;
        got.data_valid   = res.data_valid;
        got.last         = res.last;
        sb.check_word(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [BYTE_W-1:0] start_cfg;
    logic [BYTE_W-1:0] end_cfg;
    rst        = 1'b1;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    cfg.valid  = 1'b0;
    cfg.index  = '0;
    cfg.data   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_seq[i]) send_byte(directed_seq[i]);
    finish_frame();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          start_cfg = 8'h00;
          end_cfg   = 8'hFF;
        end
        1: begin
          start_cfg = 8'hFF;
          end_cfg   = 8'h00;
        end
        3: begin
          start_cfg = 8'h7E;
          end_cfg   = 8'h7E;
        end
        default: begin
          start_cfg = BYTE_W'($urandom_range(0, 255));
          end_cfg   = BYTE_W'($urandom_range(0, 255));
        end
      endcase
      quiesce();
      write_cfg(REG_START_BYTE, start_cfg);
      write_cfg(REG_END_BYTE, end_cfg);
      if (p == 2) begin
        write_cfg(REG_NONE, BYTE_W'($urandom_range(0, 255)));
        write_cfg(CFG_IDX_W'($urandom_range(2, 254)), BYTE_W'($urandom_range(0, 255)));
      end
      idling_on = (p != 4);
      // receiver backs off long enough for the input side to stall
      if (p == 1) hold_req = 1'b1;
      if (p == 3) send_frame(BYTE_W'($urandom_range(0, 255)), MAX_FRAME_DEF, 1'b1);
      run_random(20, p == 2);
      finish_frame();
    end

    quiesce();
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
